### design/dijkstra_shortest_paths_core_assert.svh
// assertion helpers for the shortest path core, sampled on clk, off during reset
`ifndef DIJKSTRA_SHORTEST_PATHS_CORE_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATHS_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define DSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsp core assertion failed");

// consequent checked in the next cycle
`define DSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsp core assertion failed");

`endif

### design/dsp_pkg.sv
package dsp_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int EDGE_WEIGHT_W = 16;
    localparam int VCOUNT_W      = 5;
    localparam int SOURCE_W      = 4;
    localparam int VIDX_OUT_W    = 4;
    localparam int PATH_DIST_W   = 20;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 5;

    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;
    localparam logic [SOURCE_W-1:0] SOURCE_VERTEX_RESET = 4'd0;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_VERTEX = 2'd1;

    typedef struct packed {
        logic [EDGE_WEIGHT_W-1:0] edge_weight;
        logic                     last_entry;
    } in_item_t;

    typedef struct packed {
        logic [VIDX_OUT_W-1:0]  vertex_index;
        logic [PATH_DIST_W-1:0] path_distance;
        logic                   reachable;
        logic                   last_result;
    } out_item_t;

    typedef enum logic [1:0] {
        MODE_SEL,
        MODE_RELAX,
        MODE_OUT
    } scan_mode_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SEL,
        ST_SEL_DRAIN,
        ST_PICK,
        ST_RELAX,
        ST_RELAX_DRAIN,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

    typedef struct packed {
        logic       load_en;
        logic       init;
        logic       rd_en;
        scan_mode_t mode;
        logic       sel_init;
        logic       pick;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic min_inf;
        logic out_free;
    } status_t;

endpackage

### design/dsp_ctrl.sv
module dsp_ctrl #(
    parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  last_entry,
    input  dsp_pkg::status_t                      status,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     nv,
    output dsp_pkg::cmd_t                         cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]       idx
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int NV_W  = $clog2(MAX_VERTICES + 1);

    dsp_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   round_reg, round_next;
    logic               cnt_last;
    logic               round_last;

    assign cnt_last   = (NV_W'(cnt_reg) + NV_W'(1)) == nv;
    assign round_last = (NV_W'(round_reg) + NV_W'(1)) == nv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsp_pkg::ST_LOAD;
            cnt_reg   <= '0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        unique case (state_reg)
            dsp_pkg::ST_LOAD:
            begin
                if (in_valid && last_entry)
                    state_next = dsp_pkg::ST_INIT;
            end
            dsp_pkg::ST_INIT:
            begin
                cnt_next   = '0;
                round_next = '0;
                state_next = dsp_pkg::ST_SEL;
            end
            dsp_pkg::ST_SEL:
            begin
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = dsp_pkg::ST_SEL_DRAIN;
                end
                else
                    cnt_next = cnt_reg + IDX_W'(1);
            end
            dsp_pkg::ST_SEL_DRAIN:
                state_next = dsp_pkg::ST_PICK;
            dsp_pkg::ST_PICK:
            begin
                // an unreachable pick ends the round without relaxing
                if (!status.min_inf)
                    state_next = dsp_pkg::ST_RELAX;
                else if (round_last)
                    state_next = dsp_pkg::ST_OUT_RD;
                else
                begin
                    round_next = round_reg + IDX_W'(1);
                    state_next = dsp_pkg::ST_SEL;
                end
            end
            dsp_pkg::ST_RELAX:
            begin
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = dsp_pkg::ST_RELAX_DRAIN;
                end
                else
                    cnt_next = cnt_reg + IDX_W'(1);
            end
            dsp_pkg::ST_RELAX_DRAIN:
            begin
                if (round_last)
                    state_next = dsp_pkg::ST_OUT_RD;
                else
                begin
                    round_next = round_reg + IDX_W'(1);
                    state_next = dsp_pkg::ST_SEL;
                end
            end
            dsp_pkg::ST_OUT_RD:
                state_next = dsp_pkg::ST_OUT_WR;
            dsp_pkg::ST_OUT_WR:
            begin
                if (status.out_free)
                begin
                    if (cnt_last)
                    begin
                        cnt_next   = '0;
                        state_next = dsp_pkg::ST_LOAD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = dsp_pkg::ST_OUT_RD;
                    end
                end
            end
            default:
                state_next = dsp_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.mode = dsp_pkg::MODE_SEL;
        idx      = cnt_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            dsp_pkg::ST_LOAD:
            begin
                in_ready    = 1'b1;
                cmd.load_en = in_valid;
            end
            dsp_pkg::ST_INIT:
                cmd.init = 1'b1;
            dsp_pkg::ST_SEL:
            begin
                cmd.rd_en    = 1'b1;
                cmd.mode     = dsp_pkg::MODE_SEL;
                cmd.sel_init = (cnt_reg == '0);
            end
            dsp_pkg::ST_SEL_DRAIN:
                cmd.mode = dsp_pkg::MODE_SEL;
            dsp_pkg::ST_PICK:
                cmd.pick = 1'b1;
            dsp_pkg::ST_RELAX:
            begin
                cmd.rd_en = 1'b1;
                cmd.mode  = dsp_pkg::MODE_RELAX;
            end
            dsp_pkg::ST_RELAX_DRAIN:
                cmd.mode = dsp_pkg::MODE_RELAX;
            dsp_pkg::ST_OUT_RD:
            begin
                cmd.rd_en = 1'b1;
                cmd.mode  = dsp_pkg::MODE_OUT;
            end
            dsp_pkg::ST_OUT_WR:
                cmd.out_load = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

### design/dsp_datapath.sv
module dsp_datapath #(
    parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dsp_pkg::cmd_t                         cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]       idx,
    input  dsp_pkg::in_item_t                     in_data,
    input  logic                                  cfg_we,
    input  logic [dsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [dsp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  out_ready,
    output dsp_pkg::status_t                      status,
    output logic [$clog2(MAX_VERTICES+1)-1:0]     nv,
    output logic                                  out_valid,
    output dsp_pkg::out_item_t                    out_data
);

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int NV_W   = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WB     = (WEIGHT_BITS < dsp_pkg::EDGE_WEIGHT_W) ?
                            WEIGHT_BITS : dsp_pkg::EDGE_WEIGHT_W;
    // one spare bit over the longest simple path
    localparam int DIST_W = WB + IDX_W + 1;
    localparam int VC_W   = dsp_pkg::VCOUNT_W;
    localparam int SRC_W  = dsp_pkg::SOURCE_W;
    localparam int VO_W   = dsp_pkg::VIDX_OUT_W;
    localparam int PD_W   = dsp_pkg::PATH_DIST_W;

    logic [WB-1:0]        wmem [DEPTH];
    logic [DIST_W-1:0]    dmem [MAX_VERTICES];

    logic [ADDR_W-1:0]    load_pos_reg;
    logic [VC_W-1:0]      vcount_reg;
    logic [SRC_W-1:0]     src_reg;
    logic [NV_W-1:0]      nv_reg;
    logic [MAX_VERTICES-1:0] inf_reg;
    logic [MAX_VERTICES-1:0] visited_reg;

    logic                 stg_valid_reg;
    dsp_pkg::scan_mode_t  stg_mode_reg;
    logic [IDX_W-1:0]     stg_idx_reg;
    logic [WB-1:0]        w_rd_reg;
    logic [DIST_W-1:0]    d_rd_reg;

    logic                 min_inf_reg;
    logic [DIST_W-1:0]    min_d_reg;
    logic [IDX_W-1:0]     u_reg;
    logic [ADDR_W-1:0]    row_base_reg;

    logic                 out_valid_reg;
    dsp_pkg::out_item_t   out_data_reg;

    logic [NV_W-1:0]      nv_load;
    logic                 src_ok;
    logic [IDX_W-1:0]     src_idx;
    logic [MAX_VERTICES-1:0] inf_init;
    logic [ADDR_W-1:0]    w_addr;
    logic [ADDR_W-1:0]    row_prod;
    logic [DIST_W-1:0]    cand;
    logic                 relax_upd;
    logic                 sel_take;
    logic                 d_we;
    logic [IDX_W-1:0]     d_waddr;
    logic [DIST_W-1:0]    d_wdata;
    logic                 out_free;
    logic                 stg_reach;

    always_comb
    begin
        if (vcount_reg == '0)
            nv_load = NV_W'(1);
        else if (32'(vcount_reg) > 32'(MAX_VERTICES))
            nv_load = NV_W'(MAX_VERTICES);
        else
            nv_load = NV_W'(vcount_reg);
    end

    // a source outside the active vertices leaves everything unreachable
    assign src_ok   = 32'(src_reg) < 32'(nv_reg);
    assign src_idx  = IDX_W'(src_reg);
    assign inf_init = ~(MAX_VERTICES'(src_ok) << src_idx);
    assign row_prod = ADDR_W'(u_reg) * ADDR_W'(nv_reg);
    assign w_addr   = row_base_reg + ADDR_W'(idx);
    assign cand     = min_d_reg + DIST_W'(w_rd_reg);

    assign relax_upd = stg_valid_reg && (stg_mode_reg == dsp_pkg::MODE_RELAX)
                       && !visited_reg[stg_idx_reg] && (w_rd_reg != '0)
                       && (inf_reg[stg_idx_reg] || (cand < d_rd_reg));

    // ties go to the later index, as with <=
    assign sel_take = stg_valid_reg && (stg_mode_reg == dsp_pkg::MODE_SEL)
                      && !visited_reg[stg_idx_reg]
                      && (inf_reg[stg_idx_reg] ? min_inf_reg
                                               : (min_inf_reg || (d_rd_reg <= min_d_reg)));

    assign d_we    = (cmd.init && src_ok) || relax_upd;
    assign d_waddr = cmd.init ? src_idx : stg_idx_reg;
    assign d_wdata = cmd.init ? '0 : cand;

    assign out_free  = !out_valid_reg || out_ready;
    assign stg_reach = !inf_reg[stg_idx_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
            wmem[load_pos_reg] <= in_data.edge_weight[WB-1:0];
        if (cmd.rd_en)
            w_rd_reg <= wmem[w_addr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            dmem[d_waddr] <= d_wdata;
        if (cmd.rd_en)
            d_rd_reg <= dmem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            vcount_reg   <= dsp_pkg::VERTEX_COUNT_RESET;
            src_reg      <= dsp_pkg::SOURCE_VERTEX_RESET;
            nv_reg       <= NV_W'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == dsp_pkg::CFG_VERTEX_COUNT)
                    vcount_reg <= cfg_data[VC_W-1:0];
                else if (cfg_index == dsp_pkg::CFG_SOURCE_VERTEX)
                    src_reg <= cfg_data[SRC_W-1:0];
            end
            if (cmd.load_en)
            begin
                if (in_data.last_entry)
                begin
                    load_pos_reg <= '0;
                    nv_reg       <= nv_load;
                end
                else if (32'(load_pos_reg) == DEPTH - 1)
                    load_pos_reg <= '0;
                else
                    load_pos_reg <= load_pos_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inf_reg     <= '1;
            visited_reg <= '0;
        end
        else if (cmd.init)
        begin
            inf_reg     <= inf_init;
            visited_reg <= '0;
        end
        else
        begin
            if (cmd.pick)
                visited_reg[u_reg] <= 1'b1;
            if (relax_upd)
                inf_reg[stg_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            stg_mode_reg  <= dsp_pkg::MODE_SEL;
            stg_idx_reg   <= '0;
            min_inf_reg   <= 1'b1;
            min_d_reg     <= '0;
            u_reg         <= '0;
            row_base_reg  <= '0;
        end
        else
        begin
            stg_valid_reg <= cmd.rd_en;
            if (cmd.rd_en)
            begin
                stg_mode_reg <= cmd.mode;
                stg_idx_reg  <= idx;
            end
            if (cmd.sel_init)
            begin
                min_inf_reg <= 1'b1;
                min_d_reg   <= '0;
                u_reg       <= '0;
            end
            else if (sel_take)
            begin
                min_inf_reg <= inf_reg[stg_idx_reg];
                min_d_reg   <= d_rd_reg;
                u_reg       <= stg_idx_reg;
            end
            if (cmd.pick)
                row_base_reg <= row_prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.vertex_index  <= VO_W'(stg_idx_reg);
            out_data_reg.path_distance <= stg_reach ? PD_W'(d_rd_reg) : '0;
            out_data_reg.reachable     <= stg_reach;
            out_data_reg.last_result   <= (NV_W'(stg_idx_reg) + NV_W'(1)) == nv_reg;
        end
    end

    assign status.min_inf  = min_inf_reg;
    assign status.out_free = out_free;
    assign nv              = nv_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

### design/dijkstra_shortest_paths_core.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data: edge_weight, last_entry
// out     | output    | out_valid / out_ready | out_data: vertex_index, path_distance,
//         |           |                       |           reachable, last_result
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// load: one matrix entry per cycle into the weight ram, no result until last_entry
// search: an init state, then per round a min scan, a pick and, for a reachable pick,
//   a relax scan; each scan reads one distance per cycle
// results: V transactions, each a read and then a load that waits for a free output
//   register; in_ready is low from last_entry until the last result is loaded into it
// reset: asynchronous, block comes up ready for load; cfg_ready is always high
module dijkstra_shortest_paths_core #(
    parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dsp_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dsp_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dsp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int NV_W  = $clog2(MAX_VERTICES + 1);

    dsp_pkg::cmd_t     cmd;
    dsp_pkg::status_t  status;
    logic [IDX_W-1:0]  idx;
    logic [NV_W-1:0]   nv;
    logic              cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    dsp_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .last_entry (in_data.last_entry),
        .status     (status),
        .nv         (nv),
        .cmd        (cmd),
        .idx        (idx)
    );

    dsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx       (idx),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .status    (status),
        .nv        (nv),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

### design/dsp_checker.sv
`include "dijkstra_shortest_paths_core_assert.svh"

module dsp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input dsp_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input dsp_pkg::out_item_t out_data
);

    // a stalled result holds
    `DSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && (out_data == $past(out_data)))

    // the final matrix entry starts the search, input closes
    `DSP_ASSERT_NEXT(a_last_closes_input, in_valid && in_ready && in_data.last_entry, !in_ready)

    // input stays closed until the final result has left the search
    `DSP_ASSERT_NOW(a_results_block_input, out_valid && out_ready && !out_data.last_result, !in_ready)

    // only the final result may still wait while loading
    `DSP_ASSERT_NOW(a_wait_only_last, out_valid && in_ready, out_data.last_result)

endmodule

bind dijkstra_shortest_paths_core dsp_checker u_dsp_checker (.*);

### bench/dijkstra_shortest_paths_core_checker.sv
module dijkstra_shortest_paths_core_checker
    import dsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_item_t              out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = MAX_VERTICES_DEF;
    localparam int CELLS = NODES * NODES;

    logic [EDGE_WEIGHT_W-1:0] matrix [CELLS];
    logic [VCOUNT_W-1:0]      vcount;
    logic [SOURCE_W-1:0]      origin;
    int                       fill_pos;
    out_item_t                expected_paths [$];
    int                       bad_count = 0;
    int                       queued = 0;

    assign mismatches = bad_count;
    assign awaited    = queued;

    function automatic int active_nodes(input logic [VCOUNT_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > NODES)
            return NODES;
        return int'(n);
    endfunction

    // o(v^2) search over the stored matrix, one expected result per vertex
    task automatic solve_paths(input int nv);
        logic [31:0]              reach_d [NODES];
        bit                       unreached [NODES];
        bit                       settled [NODES];
        bit                       best_inf;
        bit                       take;
        logic [31:0]              best_d;
        logic [31:0]              cand;
        logic [EDGE_WEIGHT_W-1:0] w;
        int                       u;
        out_item_t                r;
        for (int i = 0; i < nv; i++)
        begin
            reach_d[i]   = '0;
            unreached[i] = 1'b1;
            settled[i]   = 1'b0;
        end
        if (int'(origin) < nv)
            unreached[origin] = 1'b0;
        for (int round = 0; round < nv; round++)
        begin
            best_inf = 1'b1;
            best_d   = '0;
            u        = 0;
            // ties go to the highest index
            for (int i = 0; i < nv; i++)
            begin
                if (!settled[i])
                begin
                    if (unreached[i])
                        take = best_inf;
                    else
                        take = best_inf || (reach_d[i] <= best_d);
                    if (take)
                    begin
                        best_inf = unreached[i];
                        best_d   = reach_d[i];
                        u        = i;
                    end
                end
            end
            settled[u] = 1'b1;
            if (!unreached[u])
            begin
                for (int i = 0; i < nv; i++)
                begin
                    w = matrix[(u * nv + i) % CELLS];
                    if (!settled[i] && w != 0)
                    begin
                        cand = reach_d[u] + 32'(w);
                        if (unreached[i] || cand < reach_d[i])
                        begin
                            reach_d[i]   = cand;
                            unreached[i] = 1'b0;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < nv; i++)
        begin
            r.vertex_index  = i[VIDX_OUT_W-1:0];
            r.path_distance = unreached[i] ? '0 : reach_d[i][PATH_DIST_W-1:0];
            r.reachable     = !unreached[i];
            r.last_result   = (i == nv - 1);
            expected_paths.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            vcount   = VERTEX_COUNT_RESET;
            origin   = SOURCE_VERTEX_RESET;
            fill_pos = 0;
            expected_paths.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VERTEX_COUNT:  vcount = cfg_data[VCOUNT_W-1:0];
                    CFG_SOURCE_VERTEX: origin = cfg_data[SOURCE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_paths.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result: vertex %0d dist %0d reach %0b last %0b",
                                 out_data.vertex_index, out_data.path_distance,
                                 out_data.reachable, out_data.last_result);
                end
                else
                begin
                    want = expected_paths.pop_front();
                    if (out_data !== want)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"result mismatch: expected vertex %0d dist %0d ",
                                      "reach %0b last %0b, got vertex %0d dist %0d ",
                                      "reach %0b last %0b"},
                                     want.vertex_index, want.path_distance,
                                     want.reachable, want.last_result,
                                     out_data.vertex_index, out_data.path_distance,
                                     out_data.reachable, out_data.last_result);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                matrix[fill_pos] = in_data.edge_weight;
                fill_pos = (fill_pos + 1) % CELLS;
                if (in_data.last_entry)
                begin
                    fill_pos = 0;
                    solve_paths(active_nodes(vcount));
                end
            end
        end
        queued = expected_paths.size();
    end

endmodule

### bench/dijkstra_shortest_paths_core_test.sv
module dijkstra_shortest_paths_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dsp_pkg::*;

    // indexes that address no register
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     awaited;

    logic [VCOUNT_W-1:0]      shadow_vcount;
    logic [EDGE_WEIGHT_W-1:0] weights_q [$];
    bit                       tx_calm;
    bit                       rx_calm;
    int                       rand_items;

    dijkstra_shortest_paths_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dijkstra_shortest_paths_core_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // result side: random stall before each transaction, calm stretches have none
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = rx_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    function automatic int node_span(input logic [VCOUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_VERTICES_DEF)
            return MAX_VERTICES_DEF;
        return int'(v);
    endfunction

    // zero-heavy mix so that some vertices stay unreachable, small values for ties
    function automatic logic [EDGE_WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return '0;
        if (r == 4)
            return '1;
        if (r < 7)
            return EDGE_WEIGHT_W'($urandom_range(1, 3));
        return EDGE_WEIGHT_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    // drop the input, wait for the last result, then let the block go idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
        repeat (8) @(posedge clk);
    endtask

    // valid is left high after the last transaction; the next call or settle replaces it
    task automatic send_matrix();
        int       gap;
        in_item_t item;
        for (int k = 0; k < weights_q.size(); k++)
        begin
            gap = tx_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item.edge_weight = weights_q[k];
            item.last_entry  = (k == weights_q.size() - 1);
            in_valid <= 1'b1;
            in_data  <= item;
            do @(posedge clk); while (!(in_valid && in_ready));
        end
    endtask

    task automatic random_load(input int len);
        weights_q.delete();
        for (int k = 0; k < len; k++)
            weights_q.push_back(pick_weight());
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        send_matrix();
    endtask

    initial
    begin
        int                    nv;
        int                    sq;
        int                    len;
        int                    r;
        bit                    wrote;
        logic [CFG_DATA_W-1:0] v;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        tx_calm       = 1'b0;
        rx_calm       = 1'b0;
        shadow_vcount = VERTEX_COUNT_RESET;
        rand_items    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // six vertices, one full matrix so that later short loads read written entries
        write_reg(CFG_VERTEX_COUNT, 5'd6);
        cfg_valid <= 1'b0;
        shadow_vcount = 5'd6;
        random_load(36);

        // count of zero acts as one vertex
        settle();
        write_reg(CFG_VERTEX_COUNT, 5'd0);
        write_reg(CFG_SOURCE_VERTEX, 5'd0);
        cfg_valid <= 1'b0;
        shadow_vcount = 5'd0;
        weights_q = '{16'hFFFF};
        send_matrix();

        // source 1 given with bit 4 set, heaviest edge back to vertex 0
        settle();
        write_reg(CFG_VERTEX_COUNT, 5'd2);
        write_reg(CFG_SOURCE_VERTEX, 5'd17);
        cfg_valid <= 1'b0;
        shadow_vcount = 5'd2;
        weights_q = '{16'd0, 16'd0, 16'hFFFF, 16'd0};
        send_matrix();

        // source outside the vertex range, nothing reachable
        settle();
        write_reg(CFG_SOURCE_VERTEX, 5'd3);
        cfg_valid <= 1'b0;
        weights_q = '{16'd0, 16'd1, 16'd1, 16'd0};
        send_matrix();

        // equal distances, self loops, an ignored index
        settle();
        write_reg(CFG_VERTEX_COUNT, 5'd3);
        write_reg(CFG_SOURCE_VERTEX, 5'd0);
        write_reg(CFG_SPARE_2, 5'd31);
        cfg_valid <= 1'b0;
        shadow_vcount = 5'd3;
        weights_q = '{16'd7, 16'd2, 16'd2, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd5};
        send_matrix();

        while (rand_items < 110)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                settle();
                wrote = 1'b0;
                if ($urandom_range(0, 1) == 1)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        v = 5'd0;
                    else
                        v = CFG_DATA_W'($urandom_range(1, 6));
                    write_reg(CFG_VERTEX_COUNT, v);
                    shadow_vcount = v;
                    wrote = 1'b1;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    nv = node_span(shadow_vcount);
                    if ($urandom_range(0, 3) == 0)
                        v = CFG_DATA_W'($urandom_range(0, 31));
                    else
                        v = CFG_DATA_W'($urandom_range(0, nv - 1));
                    write_reg(CFG_SOURCE_VERTEX, v);
                    wrote = 1'b1;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                              CFG_DATA_W'($urandom));
                    wrote = 1'b1;
                end
                if (wrote)
                    cfg_valid <= 1'b0;
            end
            nv = node_span(shadow_vcount);
            sq = nv * nv;
            // every entry that a search reads is written by now, so short and long loads are both fine
            if (sq > 36)
                len = $urandom_range(1, 24);
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    len = sq;
                else if (r < 9)
                    len = $urandom_range(sq + 1, sq + 12);
                else
                    len = (sq > 1) ? $urandom_range(1, sq - 1) : 1;
            end
            random_load(len);
            rand_items += len;
        end

        settle();
        repeat (32) @(posedge clk);
        if (mismatches == 0 && awaited == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### dijkstra_shortest_paths_core.f
+incdir+design
design/dsp_pkg.sv
design/dsp_ctrl.sv
design/dsp_datapath.sv
design/dijkstra_shortest_paths_core.sv
design/dsp_checker.sv
bench/dijkstra_shortest_paths_core_checker.sv
bench/dijkstra_shortest_paths_core_test.sv
